// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms; they compile to nothing under SYNTH.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_SAME(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/wsdf_pkg.sv
// ----------------------------------------------------------------------------
// WebSocket deframer package
// Result codes, error codes, parse phases and the result beat type.
// ----------------------------------------------------------------------------
package wsdf_pkg;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_MAX_FRAME   = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_MESSAGE = 1'b1;

    localparam logic [31:0] DEF_FRAME_BYTES   = 32'd65536;
    localparam logic [31:0] DEF_MESSAGE_BYTES = 32'd1048576;

    localparam logic [6:0]  LEN7_EXT16     = 7'd126;
    localparam logic [6:0]  LEN7_EXT64     = 7'd127;
    localparam logic [63:0] CTRL_MAX_BYTES = 64'd125;
    localparam logic [3:0]  OP_CONTINUE    = 4'd0;
    localparam logic [3:0]  OP_BINARY      = 4'd2;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_EMPTY = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    typedef enum logic [3:0] {
        ERR_NONE       = 4'd0,
        ERR_RSV        = 4'd1,
        ERR_LEN_MSB    = 4'd2,
        ERR_CTRL_LONG  = 4'd3,
        ERR_CTRL_FRAG  = 4'd4,
        ERR_FRAME_BIG  = 4'd5,
        ERR_NESTED     = 4'd6,
        ERR_STRAY_CONT = 4'd7,
        ERR_MSG_BIG    = 4'd8
    } err_t;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'b01,
        PH_PAYLOAD = 2'b10
    } phase_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic [3:0] opcode;
        logic       fin;
        logic       frame_last;
        logic       message_last;
        logic       msg_binary;
        err_t       error_code;
    } result_t;

endpackage

// File: rtl/wsdf_parser.sv
// ----------------------------------------------------------------------------
// WebSocket frame parser
// Per-byte header parsing, payload unmasking and protocol checks.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wsdf_parser (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  logic [7:0]       byte_in,
    input  logic [31:0]      frame_limit,
    input  logic [31:0]      message_limit,
    output logic             push,
    output wsdf_pkg::result_t result
);
    import wsdf_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [3:0]  header_count_reg, header_count_next;
    logic [3:0]  header_need_reg, header_need_next;
    logic        fin_reg, fin_next;
    logic [3:0]  opcode_reg, opcode_next;
    logic        mask_on_reg, mask_on_next;
    logic [63:0] length_reg, length_next;
    logic [31:0] mask_key_reg, mask_key_next;
    logic [31:0] remaining_reg, remaining_next;
    logic [1:0]  mask_idx_reg, mask_idx_next;
    logic        in_message_reg, in_message_next;
    logic        binary_reg, binary_next;
    logic [31:0] msg_len_reg, msg_len_next;
    logic        error_stuck_reg, error_stuck_next;

    logic [6:0]  len7;
    logic [3:0]  ext_bytes;
    logic        hdr_done;
    logic        ctrl;
    logic        start;
    logic        bin_v;
    logic        last;
    logic [7:0]  key_byte;
    err_t        err;

    always_comb
    begin
        phase_next        = phase_reg;
        header_count_next = header_count_reg;
        header_need_next  = header_need_reg;
        fin_next          = fin_reg;
        opcode_next       = opcode_reg;
        mask_on_next      = mask_on_reg;
        length_next       = length_reg;
        mask_key_next     = mask_key_reg;
        remaining_next    = remaining_reg;
        mask_idx_next     = mask_idx_reg;
        in_message_next   = in_message_reg;
        binary_next       = binary_reg;
        msg_len_next      = msg_len_reg;
        error_stuck_next  = error_stuck_reg;

        len7      = byte_in[6:0];
        ext_bytes = header_need_reg - 4'd2 - (mask_on_reg ? 4'd4 : 4'd0);
        hdr_done  = 1'b0;
        ctrl      = opcode_reg[3];
        start     = 1'b0;
        bin_v     = binary_reg;
        last      = (remaining_reg == 32'd1);
        err       = ERR_NONE;
        push      = 1'b0;
        result    = '0;

        case (mask_idx_reg)
            2'd0:    key_byte = mask_key_reg[31:24];
            2'd1:    key_byte = mask_key_reg[23:16];
            2'd2:    key_byte = mask_key_reg[15:8];
            default: key_byte = mask_key_reg[7:0];
        endcase

        if (accept && !error_stuck_reg)
        begin
            if (phase_reg == PH_HEADER)
            begin
                header_count_next = header_count_reg + 4'd1;
                if (header_count_reg == 4'd0)
                begin
                    fin_next    = byte_in[7];
                    opcode_next = byte_in[3:0];
                    if (byte_in[6:4] != 3'd0)
                    begin
                        err = ERR_RSV;
                    end
                end
                else
                begin
                    if (header_count_reg == 4'd1)
                    begin
                        mask_on_next     = byte_in[7];
                        mask_key_next    = '0;
                        length_next      = (len7 < LEN7_EXT16) ? {57'd0, len7} : 64'd0;
                        header_need_next = 4'd2 + ((len7 == LEN7_EXT16) ? 4'd2 : 4'd0)
                                         + ((len7 == LEN7_EXT64) ? 4'd8 : 4'd0)
                                         + (byte_in[7] ? 4'd4 : 4'd0);
                    end
                    else if ((header_count_reg - 4'd2) < ext_bytes)
                    begin
                        length_next = {length_reg[55:0], byte_in};
                    end
                    else
                    begin
                        mask_key_next = {mask_key_reg[23:0], byte_in};
                    end
                    hdr_done = (header_count_next >= header_need_next);
                end

                if (hdr_done)
                begin
                    start = !ctrl && (opcode_reg != OP_CONTINUE);
                    if (length_next[63])
                    begin
                        err = ERR_LEN_MSB;
                    end
                    else if (ctrl && (length_next > CTRL_MAX_BYTES))
                    begin
                        err = ERR_CTRL_LONG;
                    end
                    else if (ctrl && !fin_reg)
                    begin
                        err = ERR_CTRL_FRAG;
                    end
                    else if (length_next > {32'd0, frame_limit})
                    begin
                        err = ERR_FRAME_BIG;
                    end
                    else if (start && in_message_reg)
                    begin
                        err = ERR_NESTED;
                    end
                    else if (!ctrl && !start && !in_message_reg)
                    begin
                        err = ERR_STRAY_CONT;
                    end
                    else
                    begin
                        if (start)
                        begin
                            bin_v        = (opcode_reg == OP_BINARY);
                            binary_next  = bin_v;
                            msg_len_next = '0;
                        end
                        if (length_next == 64'd0)
                        begin
                            push                = 1'b1;
                            result.kind         = KIND_EMPTY;
                            result.frame_last   = 1'b1;
                            result.message_last = !ctrl && fin_reg;
                            result.msg_binary   = !ctrl && bin_v;
                            if (!ctrl)
                            begin
                                in_message_next = !fin_reg;
                                if (fin_reg)
                                begin
                                    msg_len_next = '0;
                                end
                            end
                            header_count_next = 4'd0;
                            header_need_next  = 4'd2;
                        end
                        else
                        begin
                            if (!ctrl)
                            begin
                                in_message_next = 1'b1;
                            end
                            remaining_next = length_next[31:0];
                            mask_idx_next  = 2'd0;
                            phase_next     = PH_PAYLOAD;
                        end
                    end
                end
            end
            else
            begin
                if (!ctrl && (msg_len_reg >= message_limit))
                begin
                    err = ERR_MSG_BIG;
                end
                else
                begin
                    if (!ctrl)
                    begin
                        msg_len_next = msg_len_reg + 32'd1;
                    end
                    mask_idx_next       = mask_idx_reg + 2'd1;
                    remaining_next      = remaining_reg - 32'd1;
                    push                = 1'b1;
                    result.kind         = KIND_DATA;
                    result.data         = byte_in ^ (mask_on_reg ? key_byte : 8'd0);
                    result.frame_last   = last;
                    result.message_last = !ctrl && last && fin_reg;
                    result.msg_binary   = !ctrl && binary_reg;
                    if (last)
                    begin
                        if (!ctrl)
                        begin
                            in_message_next = !fin_reg;
                            if (fin_reg)
                            begin
                                msg_len_next = '0;
                            end
                        end
                        phase_next        = PH_HEADER;
                        header_count_next = 4'd0;
                        header_need_next  = 4'd2;
                    end
                end
            end

            if (err != ERR_NONE)
            begin
                error_stuck_next    = 1'b1;
                push                = 1'b1;
                result              = '0;
                result.kind         = KIND_ERROR;
                result.error_code   = err;
            end
        end

        result.opcode = opcode_next;
        result.fin    = fin_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_HEADER;
            header_count_reg <= '0;
            header_need_reg  <= 4'd2;
            fin_reg          <= 1'b0;
            opcode_reg       <= '0;
            mask_on_reg      <= 1'b0;
            length_reg       <= '0;
            mask_key_reg     <= '0;
            remaining_reg    <= '0;
            mask_idx_reg     <= '0;
            in_message_reg   <= 1'b0;
            binary_reg       <= 1'b0;
            msg_len_reg      <= '0;
            error_stuck_reg  <= 1'b0;
        end
        else
        begin
            phase_reg        <= phase_next;
            header_count_reg <= header_count_next;
            header_need_reg  <= header_need_next;
            fin_reg          <= fin_next;
            opcode_reg       <= opcode_next;
            mask_on_reg      <= mask_on_next;
            length_reg       <= length_next;
            mask_key_reg     <= mask_key_next;
            remaining_reg    <= remaining_next;
            mask_idx_reg     <= mask_idx_next;
            in_message_reg   <= in_message_next;
            binary_reg       <= binary_next;
            msg_len_reg      <= msg_len_next;
            error_stuck_reg  <= error_stuck_next;
        end
    end

    `ASSERT_NEXT(a_error_sticks, clk, rst_n, error_stuck_reg, error_stuck_reg)
    `ASSERT_SAME(a_payload_nonempty, clk, rst_n, phase_reg == PH_PAYLOAD,
                 remaining_reg != 32'd0)
    `ASSERT_SAME(a_silent_after_error, clk, rst_n, error_stuck_reg, !push)

endmodule

// File: rtl/wsdf_outbuf.sv
// ----------------------------------------------------------------------------
// WebSocket deframer result buffer
// Output register with one skid entry; the input stalls only while both hold.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wsdf_outbuf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  wsdf_pkg::result_t push_data,
    output logic              full,
    output logic              out_valid,
    input  logic              out_stall,
    output wsdf_pkg::result_t out_data
);
    import wsdf_pkg::*;

    logic    main_valid_reg, main_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t main_reg, main_next;
    result_t skid_reg, skid_next;
    logic    pop;

    assign pop       = main_valid_reg && !out_stall;
    assign full      = skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!main_valid_reg || pop)
            begin
                main_next       = push_data;
                main_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = push_data;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    `ASSERT_SAME(a_skid_behind_main, clk, rst_n, skid_valid_reg, main_valid_reg)
    `ASSERT_NEXT(a_skid_catches, clk, rst_n, push && main_valid_reg && out_stall,
                 skid_valid_reg)
    `ASSERT_NEXT(a_skid_drains, clk, rst_n, skid_valid_reg && !out_stall,
                 main_valid_reg && !skid_valid_reg)

endmodule

// File: rtl/websocket_frame_deframer.sv
// ----------------------------------------------------------------------------
// WebSocket frame deframer
// Receive-side frame header parser, payload unmasker and protocol checker.
// ----------------------------------------------------------------------------
// The block takes one received byte per beat and accepts a new byte on every
// clock cycle while in_stall is low; each byte's result is registered in the
// output buffer after the parser logic. Header bytes give no result, payload
// bytes give one unmasked data beat, a frame with an empty payload gives one
// end beat, and a protocol violation gives one error beat after which all
// bytes are consumed silently until reset. The output has a two-entry buffer,
// and in_stall is high exactly while two results are waiting for the
// consumer. Register 0 sets the largest frame payload and register 1 the
// largest message payload; a zero value selects 65536 and 1048576 bytes.
`include "assert_macros.svh"

module websocket_frame_deframer (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [wsdf_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [wsdf_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [7:0]                         byte_in,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [1:0]                         result_kind,
    output logic [7:0]                         data_out,
    output logic [3:0]                         frame_opcode,
    output logic                               frame_fin,
    output logic                               frame_last,
    output logic                               message_last,
    output logic                               message_is_binary,
    output logic [3:0]                         error_code
);
    import wsdf_pkg::*;

    logic [31:0] max_frame_reg;
    logic [31:0] max_message_reg;
    logic [31:0] frame_limit;
    logic [31:0] message_limit;
    logic        accept;
    logic        push;
    result_t     push_data;
    result_t     out_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_frame_reg   <= DEF_FRAME_BYTES;
            max_message_reg <= DEF_MESSAGE_BYTES;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MAX_FRAME:   max_frame_reg   <= cfg_data;
                REG_MAX_MESSAGE: max_message_reg <= cfg_data;
                default:         max_frame_reg   <= max_frame_reg;
            endcase
        end
    end

    assign frame_limit   = (max_frame_reg == 32'd0) ? DEF_FRAME_BYTES : max_frame_reg;
    assign message_limit = (max_message_reg == 32'd0) ? DEF_MESSAGE_BYTES : max_message_reg;
    assign accept        = in_valid && !in_stall;

    wsdf_parser u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .byte_in       (byte_in),
        .frame_limit   (frame_limit),
        .message_limit (message_limit),
        .push          (push),
        .result        (push_data)
    );

    wsdf_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign result_kind       = out_data.kind;
    assign data_out          = out_data.data;
    assign frame_opcode      = out_data.opcode;
    assign frame_fin         = out_data.fin;
    assign frame_last        = out_data.frame_last;
    assign message_last      = out_data.message_last;
    assign message_is_binary = out_data.msg_binary;
    assign error_code        = out_data.error_code;

    `ASSERT_SAME(a_kind_legal, clk, rst_n, out_valid,
                 result_kind == KIND_DATA || result_kind == KIND_EMPTY
                 || result_kind == KIND_ERROR)
    `ASSERT_SAME(a_error_has_code, clk, rst_n, out_valid && result_kind == KIND_ERROR,
                 error_code != ERR_NONE && !frame_last && data_out == 8'd0)
    `ASSERT_SAME(a_data_no_code, clk, rst_n, out_valid && result_kind != KIND_ERROR,
                 error_code == ERR_NONE)

endmodule
